// ----- rtl/core/rrip_set_dueling_selector_unit_defines.svh -----
// Assertion macros shared by the set-dueling selector RTL.
`ifndef RRIP_SET_DUELING_SELECTOR_UNIT_DEFINES_SVH
`define RRIP_SET_DUELING_SELECTOR_UNIT_DEFINES_SVH

// Clocked on clk and switched off while rst_n is low.
`define RSDSEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk and also checked while reset is applied.
`define RSDSEL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rsdsel_pkg.sv -----
// Types, codes and constants shared by the set-dueling selector modules.
package rsdsel_pkg;

  localparam int SET_INDEX_W = 16;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 2;
  localparam int THRESH_W    = 8;
  localparam int CNT_OUT_W   = 8;
  localparam int SET_FIELD_W = 5;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int SELECTOR_BITS_DEF = 30;
  localparam int THROTTLE_BITS_DEF = 8;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd32;
  localparam logic [0:0]          REG_THRESH   = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_SRRIP  = 2'd0,
    KIND_BRRIP  = 2'd1,
    KIND_FOLLOW = 2'd2
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FILL = 2'd0,
    MODE_HIT  = 2'd1,
    MODE_REPL = 2'd2
  } mode_t;

  typedef struct packed {
    kind_t kind;
    logic  fill;
    logic  spill;
  } req_t;

endpackage

// ----- rtl/core/rrip_set_dueling_selector_unit.sv -----
// Top level of the DRRIP set-dueling selector: pipeline, config register and result.
// Usage:
// Requests arrive on the in_ channel (valid/ready) as a set index, a mode and a spill
// flag; each beat yields exactly one result beat on the out_ channel carrying the
// chosen insertion policy, the access throttle value and the set kind.
// A request is taken into an input register; from there the duel selector and throttle
// counters are updated and the result register is loaded once that register is free or
// draining, which raises out_valid.
// Throughput is one request per clock while the receiver does not stall; the state update
// sits between the input register and the result register.
// The throttle period lives in a single APB register at byte address 0; the user must write it
// only while no request is in flight (the block itself does not enforce this), and pready is always high.
// A synchronous active-low reset empties the pipeline, sets the selector to its
// midpoint, clears all throttle counters and sets the period to 32.
// When the receiver stalls, the result register holds its beat and one further
// request is taken into the input register; in_ready then drops until out_ready
// returns.
`include "rrip_set_dueling_selector_unit_defines.svh"
module rrip_set_dueling_selector_unit
  import rsdsel_pkg::*;
#(
  parameter int SELECTOR_BITS = SELECTOR_BITS_DEF,
  parameter int THROTTLE_BITS = THROTTLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SET_INDEX_W-1:0] in_set_index,
  input  logic [MODE_W-1:0]      in_mode,
  input  logic                   in_spill,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_use_bimodal,
  output logic [CNT_OUT_W-1:0]   out_throttle_count,
  output logic [KIND_W-1:0]      out_set_kind,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  req_t                     req_in;
  req_t                     s1_req_r;
  logic                     s1_v_r;
  logic                     s1_v_nxt;
  logic                     out_v_r;
  logic                     out_v_nxt;
  logic                     advance;
  logic                     in_acc;
  logic                     fire;
  logic [THRESH_W-1:0]      thresh_r;
  logic                     cfg_wr;
  logic                     samp_step;
  logic                     foll_step;
  logic [THROTTLE_BITS-1:0] samp_cnt_nxt;
  logic [THROTTLE_BITS-1:0] foll_cnt_nxt;
  logic [THROTTLE_BITS-1:0] acc_thr_r;
  logic [THROTTLE_BITS-1:0] acc_thr_nxt;
  logic                     follow_srrip;
  logic                     use_bim_nxt;
  logic                     use_bim_r;
  logic [CNT_OUT_W-1:0]     thr_out_r;
  kind_t                    kind_out_r;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2:2] == REG_THRESH);
  assign cfg_prdata = (cfg_paddr[2:2] == REG_THRESH) ? CFG_DATA_W'(thresh_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr) begin
      thresh_r <= cfg_pwdata[THRESH_W-1:0];
    end
  end

  // Input stage.
  rsdsel_classify u_classify (
    .set_index_i (in_set_index),
    .mode_i      (in_mode),
    .spill_i     (in_spill),
    .req_o       (req_in)
  );

  assign advance  = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || advance;
  assign in_acc   = in_valid && in_ready;
  assign fire     = advance && s1_v_r;

  always_comb begin
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
    out_v_nxt = advance ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= req_in;
    end
  end

  // Update stage.
  assign samp_step = fire && s1_req_r.fill && (s1_req_r.kind == KIND_BRRIP);
  assign foll_step = fire && s1_req_r.fill && (s1_req_r.kind == KIND_FOLLOW);

  rsdsel_selector #(
    .SELECTOR_BITS (SELECTOR_BITS)
  ) u_selector (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_i           (fire && s1_req_r.fill && (s1_req_r.kind == KIND_SRRIP)),
    .down_i         (samp_step),
    .follow_srrip_o (follow_srrip)
  );

  rsdsel_throttle #(
    .THROTTLE_BITS (THROTTLE_BITS)
  ) u_samp_thr (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (samp_step),
    .thresh_i  (thresh_r),
    .cnt_nxt_o (samp_cnt_nxt)
  );

  rsdsel_throttle #(
    .THROTTLE_BITS (THROTTLE_BITS)
  ) u_foll_thr (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (foll_step),
    .thresh_i  (thresh_r),
    .cnt_nxt_o (foll_cnt_nxt)
  );

  always_comb begin
    if (samp_step) begin
      acc_thr_nxt = samp_cnt_nxt;
    end else if (foll_step) begin
      acc_thr_nxt = foll_cnt_nxt;
    end else begin
      acc_thr_nxt = acc_thr_r;
    end
    use_bim_nxt = !(s1_req_r.spill || (s1_req_r.kind == KIND_SRRIP)
                    || ((s1_req_r.kind == KIND_FOLLOW) && follow_srrip));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_thr_r <= '0;
    end else begin
      acc_thr_r <= acc_thr_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (fire) begin
      use_bim_r  <= use_bim_nxt;
      thr_out_r  <= CNT_OUT_W'(acc_thr_nxt);
      kind_out_r <= s1_req_r.kind;
    end
  end

  assign out_valid          = out_v_r;
  assign out_use_bimodal    = use_bim_r;
  assign out_throttle_count = thr_out_r;
  assign out_set_kind       = kind_out_r;

  `RSDSEL_ASSERT(s1_held_on_stall, (s1_v_r && out_v_r && !out_ready) |=> s1_v_r, "Queued beat lost during stall.")
  `RSDSEL_ASSERT(out_from_s1, $rose(out_v_r) |-> $past(s1_v_r), "Result beat appeared without a request.")
  `RSDSEL_ASSERT_RST(reset_empties, !rst_n |=> (!out_v_r && !s1_v_r), "Pipeline not empty after reset.")
  `RSDSEL_ASSERT(thr_samp_bound, $countones({samp_step, foll_step}) <= 1, "Two throttles stepped at once.")

endmodule

// ----- rtl/core/rsdsel_classify.sv -----
// Request decoder: set kind from the set index, fill flag and effective spill.
module rsdsel_classify
  import rsdsel_pkg::*;
(
  input  logic [SET_INDEX_W-1:0] set_index_i,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic                   spill_i,
  output req_t                   req_o
);

  logic [SET_FIELD_W-1:0] lo;
  logic [SET_FIELD_W-1:0] hi;

  assign lo = set_index_i[SET_FIELD_W-1:0];
  assign hi = set_index_i[2*SET_FIELD_W-1:SET_FIELD_W];

  always_comb begin
    if (lo == hi) begin
      req_o.kind = KIND_SRRIP;
    end else if (lo == ~hi) begin
      req_o.kind = KIND_BRRIP;
    end else begin
      req_o.kind = KIND_FOLLOW;
    end
    case (mode_t'(mode_i))
      MODE_FILL: begin
        req_o.fill  = 1'b1;
        req_o.spill = spill_i;
      end
      MODE_HIT: begin
        req_o.fill  = 1'b0;
        req_o.spill = spill_i;
      end
      MODE_REPL: begin
        req_o.fill  = 1'b0;
        req_o.spill = 1'b0;
      end
      default: begin
        req_o.fill  = 1'b0;
        req_o.spill = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/rsdsel_throttle.sv -----
// Bimodal throttle counter that wraps to zero at the programmed period.
module rsdsel_throttle
  import rsdsel_pkg::*;
#(
  parameter int THROTTLE_BITS = THROTTLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_i,
  input  logic [THRESH_W-1:0]      thresh_i,
  output logic [THROTTLE_BITS-1:0] cnt_nxt_o
);

  localparam int CMP_W = THRESH_W + 1;

  logic [THROTTLE_BITS-1:0] cnt_r;
  logic [THROTTLE_BITS-1:0] cnt_nxt;
  logic [CMP_W-1:0]         cnt_inc;

  assign cnt_inc = CMP_W'(cnt_r) + CMP_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (step_i) begin
      if (cnt_inc < CMP_W'(thresh_i)) begin
        if (cnt_r != {THROTTLE_BITS{1'b1}}) begin
          cnt_nxt = cnt_r + THROTTLE_BITS'(1);
        end
      end else begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt_nxt_o = cnt_nxt;

endmodule

// ----- rtl/core/rsdsel_selector.sv -----
// Saturating duel selector between the SRRIP and BRRIP sample sets.
`include "rrip_set_dueling_selector_unit_defines.svh"
module rsdsel_selector
  import rsdsel_pkg::*;
#(
  parameter int SELECTOR_BITS = SELECTOR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_i,
  input  logic down_i,
  output logic follow_srrip_o
);

  localparam int SW = SELECTOR_BITS + 1;
  localparam logic [SW-1:0] SEL_MAX = {1'b1, {SELECTOR_BITS{1'b0}}};
  localparam logic [SW-1:0] SEL_MID = {2'b01, {(SELECTOR_BITS-1){1'b0}}};

  logic [SW-1:0] sel_r;
  logic [SW-1:0] sel_nxt;

  always_comb begin
    sel_nxt = sel_r;
    if (up_i && (sel_r < SEL_MAX)) begin
      sel_nxt = sel_r + SW'(1);
    end else if (down_i && (sel_r != '0)) begin
      sel_nxt = sel_r - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= SEL_MID;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  assign follow_srrip_o = (sel_nxt <= SEL_MID);

  `RSDSEL_ASSERT(sel_in_range, sel_r <= SEL_MAX, "Selector beyond its saturation limit.")
  `RSDSEL_ASSERT(sel_hold, !(up_i || down_i) |=> $stable(sel_r), "Selector moved without a fill.")

endmodule
